// ----- src/ole_pkg.sv -----
// Package for the ordered list engine: operation and status codes,
// field widths and the per-cell control bundle. No dependencies.
package ole_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int OP_W    = 3;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 9;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_VAL  = 3'd5;
    localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;
    localparam logic [OP_W-1:0] OP_COUNT    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOVAL   = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd5;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic cmp_en;     // latch match flags
        logic upd_en;     // apply the shift this cycle
        logic ins;        // open a slot at idx
        logic del;        // close the slot at idx
        logic del_match;  // close the slot at the first match instead of idx
    } t_cell_ctl;

endpackage

// ----- src/ordered_list_engine.sv -----
// Top level of the ordered list engine: request decode, chain of storage
// cells, match scan and result register. Uses ole_pkg, ole_cell, ole_scan.
//
// Bounded ordered list of up to DEPTH signed 32-bit entries, head first.
// A transaction is captured on the input channel, its value is compared
// against every cell in the next cycle, and in the apply step after that
// the cells shift in parallel and the result lands in the output register.
// A new request is not taken before the previous one reaches its shift
// step; the next request is taken in the same cycle the shift completes.
// A held result blocks the shift step, and the next request waits with it;
// a request can still be captured from idle while a result is held. Insert
// into a full list answers "full" and leaves the list as it was.
module ordered_list_engine #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [ole_pkg::OP_W-1:0]          i_op,
    input  logic [ole_pkg::POS_W-1:0]         i_position,
    input  logic signed [ole_pkg::VAL_W-1:0]  i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ole_pkg::STAT_W-1:0]        o_status,
    output logic signed [ole_pkg::VAL_W-1:0]  o_removed_value,
    output logic [ole_pkg::CNT_W-1:0]         o_found_position,
    output logic [ole_pkg::CNT_W-1:0]         o_entry_count
);
    import ole_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [OP_W-1:0]   r_op;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_req_val;
    logic [CW-1:0]     r_occ, n_occ;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [VAL_W-1:0]  r_removed;
    logic [CNT_W-1:0]  r_found;
    logic [CNT_W-1:0]  r_count;

    logic              w_in_acc;
    logic              w_apply_go;
    t_cell_ctl         w_ctl;
    logic [STAT_W-1:0] w_status;
    logic              w_ins, w_del, w_del_match, w_use_pos, w_report;
    logic [IW-1:0]     w_idx;
    logic              w_full;

    logic [VAL_W-1:0]  w_cell_val [DEPTH];
    logic [DEPTH-1:0]  w_match;
    logic [DEPTH-1:0]  w_incl;
    logic              w_any;
    logic [VAL_W-1:0]  w_sel_val;
    logic [IW-1:0]     w_sel_idx;

    assign w_apply_go = (r_state == S_APPLY) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = !((r_state == S_IDLE) || w_apply_go);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_occ == FULL_CNT);

    always_comb begin
        w_status    = ST_OK;
        w_ins       = 1'b0;
        w_del       = 1'b0;
        w_del_match = 1'b0;
        w_use_pos   = 1'b1;
        w_report    = 1'b0;
        w_idx       = '0;
        n_occ       = r_occ;
        case (r_op)
            OP_INS_HEAD: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    n_occ = r_occ + CW'(1);
                end
            end
            OP_INS_TAIL: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_idx = IW'(r_occ);
                    n_occ = r_occ + CW'(1);
                end
            end
            OP_INS_POS: begin
                if (r_pos == '0) begin
                    w_status = ST_INVALID;
                end else if (w_full) begin
                    w_status = ST_FULL;
                end else if (CNT_W'(r_pos) > (CNT_W'(r_occ) + CNT_W'(1))) begin
                    w_status = ST_NOPOS;
                end else begin
                    w_ins = 1'b1;
                    w_idx = IW'(r_pos - POS_W'(1));
                    n_occ = r_occ + CW'(1);
                end
            end
            OP_DEL_HEAD: begin
                if (r_occ == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                    n_occ = r_occ - CW'(1);
                end
            end
            OP_DEL_TAIL: begin
                if (r_occ == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_del = 1'b1;
                    w_idx = IW'(r_occ - CW'(1));
                    n_occ = r_occ - CW'(1);
                end
            end
            OP_DEL_VAL: begin
                w_use_pos = 1'b0;
                if (r_occ == '0) begin
                    w_status = ST_EMPTY;
                end else if (!w_any) begin
                    w_status = ST_NOVAL;
                end else begin
                    w_del       = 1'b1;
                    w_del_match = 1'b1;
                    n_occ       = r_occ - CW'(1);
                end
            end
            OP_SEARCH: begin
                w_use_pos = 1'b0;
                if (!w_any) begin
                    w_status = ST_NOVAL;
                end else begin
                    w_report = 1'b1;
                end
            end
            OP_COUNT: begin
                w_status = ST_OK;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    assign w_ctl.cmp_en    = (r_state == S_CMP);
    assign w_ctl.upd_en    = w_apply_go;
    assign w_ctl.ins       = w_ins;
    assign w_ctl.del       = w_del;
    assign w_ctl.del_match = w_del_match;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;
        if (g == 0) begin : g_head
            assign w_left = w_cell_val[g];
        end else begin : g_mid_l
            assign w_left = w_cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = w_cell_val[g];
        end else begin : g_mid_r
            assign w_right = w_cell_val[g+1];
        end
        ole_cell #(
            .DEPTH (DEPTH),
            .INDEX (g),
            .IW    (IW),
            .CW    (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_idx     (w_idx),
            .i_occ     (r_occ),
            .i_req_val (r_req_val),
            .i_left    (w_left),
            .i_right   (w_right),
            .i_incl    (w_incl[g]),
            .o_val     (w_cell_val[g]),
            .o_match   (w_match[g])
        );
    end

    ole_scan #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_scan (
        .i_match   (w_match),
        .i_use_pos (w_use_pos),
        .i_idx     (w_idx),
        .i_val     (w_cell_val),
        .o_incl    (w_incl),
        .o_any     (w_any),
        .o_sel_val (w_sel_val),
        .o_sel_idx (w_sel_idx)
    );

    always_comb begin
        n_state = r_state;
        if (w_in_acc) begin
            n_state = S_CMP;
        end else if (r_state == S_CMP) begin
            n_state = S_APPLY;
        end else if (w_apply_go) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply_go) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op      <= i_op;
            r_pos     <= i_position;
            r_req_val <= i_value;
        end
        if (w_apply_go) begin
            r_status  <= w_status;
            r_removed <= w_del ? w_sel_val : '0;
            r_found   <= w_report ? (CNT_W'(w_sel_idx) + CNT_W'(1)) : '0;
            r_count   <= CNT_W'(n_occ);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_removed_value  = $signed(r_removed);
    assign o_found_position = r_found;
    assign o_entry_count    = r_count;

endmodule

// ----- src/ole_cell.sv -----
// One storage cell of the list chain: holds an entry and its match flag,
// shifts toward head or tail from its neighbors. Uses ole_pkg.
module ole_cell #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF,
    parameter int INDEX = 0,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic                       i_clk,
    input  ole_pkg::t_cell_ctl         i_ctl,
    input  logic [IW-1:0]              i_idx,
    input  logic [CW-1:0]              i_occ,
    input  logic [ole_pkg::VAL_W-1:0]  i_req_val,
    input  logic [ole_pkg::VAL_W-1:0]  i_left,
    input  logic [ole_pkg::VAL_W-1:0]  i_right,
    input  logic                       i_incl,
    output logic [ole_pkg::VAL_W-1:0]  o_val,
    output logic                       o_match
);
    import ole_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

    logic [VAL_W-1:0] r_val;
    logic             r_match;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_match <= (MY_CNT < i_occ) && (r_val == i_req_val);
        end
        if (i_ctl.upd_en) begin
            if (i_ctl.ins) begin
                if (MY_IDX > i_idx) begin
                    r_val <= i_left;
                end else if (MY_IDX == i_idx) begin
                    r_val <= i_req_val;
                end
            end else if (i_ctl.del) begin
                // cells at or past the removed slot pull from the tail side
                if (i_ctl.del_match ? i_incl : (MY_IDX >= i_idx)) begin
                    r_val <= i_right;
                end
            end
        end
    end

    assign o_val   = r_val;
    assign o_match = r_match;

endmodule

// ----- src/ole_scan.sv -----
// Match scan across the chain: log-depth prefix OR, first-match pick and
// one-hot readout of the selected entry. Uses ole_pkg.
module ole_scan #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF,
    parameter int IW    = 4
) (
    input  logic [DEPTH-1:0]           i_match,
    input  logic                       i_use_pos,
    input  logic [IW-1:0]              i_idx,
    input  logic [ole_pkg::VAL_W-1:0]  i_val [DEPTH],
    output logic [DEPTH-1:0]           o_incl,
    output logic                       o_any,
    output logic [ole_pkg::VAL_W-1:0]  o_sel_val,
    output logic [IW-1:0]              o_sel_idx
);
    import ole_pkg::*;

    logic [DEPTH-1:0] w_pre;
    logic [DEPTH-1:0] w_first;
    logic [DEPTH-1:0] w_sel;

    always_comb begin
        w_pre = i_match;
        for (int l = 0; l < IW; l++) begin
            w_pre = w_pre | (w_pre << (1 << l));
        end
    end

    assign o_incl  = w_pre;
    assign w_first = i_match & ~(w_pre << 1);
    assign o_any   = |i_match;

    always_comb begin
        o_sel_val = '0;
        o_sel_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel[i]  = i_use_pos ? (IW'(i) == i_idx) : w_first[i];
            o_sel_val = o_sel_val | ({VAL_W{w_sel[i]}} & i_val[i]);
            o_sel_idx = o_sel_idx | ({IW{w_sel[i]}} & IW'(i));
        end
    end

endmodule

// ----- src/ole_checker.sv -----
// Port-level checks for the ordered list engine, bound to the top level.
// Uses ole_pkg.
module ole_checker #(
    parameter int DEPTH = ole_pkg::DEPTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [ole_pkg::STAT_W-1:0]        o_status,
    input logic signed [ole_pkg::VAL_W-1:0]  o_removed_value,
    input logic [ole_pkg::CNT_W-1:0]         o_found_position,
    input logic [ole_pkg::CNT_W-1:0]         o_entry_count
);
    import ole_pkg::*;

    // held result must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_removed_value) && $stable(o_entry_count))
        else $error("result changed while stalled");

    // compare cycle follows every accepted transaction
    a_in_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted on back-to-back cycles");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |->
            (o_removed_value == '0) && (o_found_position == '0))
        else $error("failed request reports data");

    a_found_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_found_position != '0) |->
            (o_status == ST_OK) && (o_found_position <= o_entry_count))
        else $error("match position outside list");

endmodule

bind ordered_list_engine ole_checker #(.DEPTH(DEPTH)) u_ole_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_status         (o_status),
    .o_removed_value  (o_removed_value),
    .o_found_position (o_found_position),
    .o_entry_count    (o_entry_count)
);

// ----- test/ordered_list_engine_tb.sv -----
`timescale 1ns / 100ps
// Testbench for ordered_list_engine: directed and random list requests with
// a queue-fed driver, a checking monitor and a local list predictor. Uses ole_pkg.
module ordered_list_engine_tb;
    import ole_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int HOLD_AT    = 700;   // results seen before the long receiver hold
    localparam int HOLD_LEN   = 80;
    localparam int PHASE_LEN  = 283;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
    } list_req_t;

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] removed;
        logic [CNT_W-1:0]        found;
        logic [CNT_W-1:0]        count;
    } list_result_t;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_op = '0;
    logic [POS_W-1:0]           i_position = '0;
    logic signed [VAL_W-1:0]    i_value = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic [STAT_W-1:0]          o_status;
    logic signed [VAL_W-1:0]    o_removed_value;
    logic [CNT_W-1:0]           o_found_position;
    logic [CNT_W-1:0]           o_entry_count;

    list_req_t    pending_reqs[$];
    list_result_t result_q[$];
    list_result_t want_r;

    logic signed [VAL_W-1:0] list_mem [0:LIST_DEPTH-1];
    int list_len = 0;

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int error_cnt = 0;
    int results_seen = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    ordered_list_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_removed_value  (o_removed_value),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_error(input string what);
        $display("ERROR @%0t: %s", $time, what);
        error_cnt++;
    endtask

    // --- list predictor -------------------------------------------------
    task automatic list_insert(input int idx, input logic signed [VAL_W-1:0] v);
        for (int k = list_len; k > idx; k--)
            list_mem[k] = list_mem[k-1];
        list_mem[idx] = v;
        list_len++;
    endtask

    function automatic logic signed [VAL_W-1:0] list_remove(input int idx);
        logic signed [VAL_W-1:0] v;
        v = list_mem[idx];
        for (int k = idx; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k+1];
        list_len--;
        return v;
    endfunction

    // index of first match, list_len when absent
    function automatic int list_find(input logic signed [VAL_W-1:0] v);
        for (int k = 0; k < list_len; k++)
            if (list_mem[k] == v)
                return k;
        return list_len;
    endfunction

    task automatic predict_list_op(input list_req_t rq);
        list_result_t res;
        int idx;
        res.status  = ST_OK;
        res.removed = '0;
        res.found   = '0;
        case (rq.op)
            OP_INS_HEAD, OP_INS_TAIL: begin
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                    list_insert((rq.op == OP_INS_HEAD) ? 0 : list_len, rq.val);
            end
            OP_INS_POS: begin
                if (rq.pos == '0)
                    res.status = ST_INVALID;
                else if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else if (int'(rq.pos) > list_len + 1)
                    res.status = ST_NOPOS;
                else
                    list_insert(int'(rq.pos) - 1, rq.val);
            end
            OP_DEL_HEAD, OP_DEL_TAIL: begin
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    res.removed = list_remove((rq.op == OP_DEL_HEAD) ? 0 : list_len - 1);
            end
            OP_DEL_VAL: begin
                if (list_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    idx = list_find(rq.val);
                    if (idx >= list_len)
                        res.status = ST_NOVAL;
                    else
                        res.removed = list_remove(idx);
                end
            end
            OP_SEARCH: begin
                idx = list_find(rq.val);
                if (idx >= list_len)
                    res.status = ST_NOVAL;
                else
                    res.found = CNT_W'(idx + 1);
            end
            default: ;
        endcase
        res.count = CNT_W'(list_len);
        result_q.push_back(res);
    endtask

    // --- driver ---------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                predict_list_op('{op: i_op, pos: i_position, val: i_value});
            if (!i_in_valid || !o_in_stall) begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_op       <= pending_reqs[0].op;
                    i_position <= pending_reqs[0].pos;
                    i_value    <= pending_reqs[0].val;
                    void'(pending_reqs.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // --- monitor and receiver stall ---------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    report_error("output transaction with no expected result");
                end else begin
                    want_r = result_q.pop_front();
                    if (o_status !== want_r.status)
                        report_error($sformatf("status got %0d want %0d",
                                               o_status, want_r.status));
                    if (o_removed_value !== want_r.removed)
                        report_error($sformatf("removed_value got %0d want %0d",
                                               o_removed_value, want_r.removed));
                    if (o_found_position !== want_r.found)
                        report_error($sformatf("found_position got %0d want %0d",
                                               o_found_position, want_r.found));
                    if (o_entry_count !== want_r.count)
                        report_error($sformatf("entry_count got %0d want %0d",
                                               o_entry_count, want_r.count));
                end
            end
            // one long hold so the block backs up and stalls its input
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle_pct);
            end
        end
    end

    // --- stimulus ---------------------------------------------------------
    task automatic push_req(input logic [OP_W-1:0] op, input int pos,
                            input logic signed [VAL_W-1:0] val);
        pending_reqs.push_back('{op: op, pos: POS_W'(pos), val: val});
    endtask

    // grow_pct: share of inserts, the rest are deletes, searches and counts
    function automatic list_req_t make_req(input int grow_pct);
        list_req_t rq;
        if ($urandom_range(99) < grow_pct)
            rq.op = OP_W'($urandom_range(2, 0));
        else
            rq.op = OP_W'($urandom_range(7, 3));
        if ($urandom_range(9) == 0)
            rq.pos = POS_W'($urandom_range(255, 0));
        else
            rq.pos = POS_W'($urandom_range(17, 1));
        // small values make duplicates, so searches and deletes hit
        if ($urandom_range(9) < 6)
            rq.val = VAL_W'(int'($urandom_range(8, 0)) - 4);
        else
            rq.val = $urandom;
        return rq;
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_in_valid || result_q.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        int grow;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        snd_idle_pct = 25;
        rcv_idle_pct = 70;

        // empty list cases
        push_req(OP_DEL_HEAD, 0, 0);
        push_req(OP_DEL_TAIL, 0, 0);
        push_req(OP_DEL_VAL, 0, 5);
        push_req(OP_SEARCH, 0, 5);
        push_req(OP_INS_POS, 0, -1);             // position zero
        push_req(OP_INS_POS, 2, 1);              // beyond tail
        push_req(OP_INS_POS, 1, 32'h7FFF_FFFF);
        push_req(OP_INS_HEAD, 0, 32'h8000_0000);
        push_req(OP_INS_TAIL, 255, 0);
        for (int k = 0; k < 13; k++) begin
            if (k % 3 == 0)
                push_req(OP_INS_POS, k + 2, k);
            else
                push_req(OP_INS_TAIL, 0, k);
        end
        // list is full now
        push_req(OP_INS_HEAD, 0, 1);
        push_req(OP_INS_TAIL, 0, 2);
        push_req(OP_INS_POS, 17, 3);
        push_req(OP_INS_POS, 0, 4);              // zero position wins over full
        push_req(OP_SEARCH, 0, 32'h8000_0000);
        push_req(OP_DEL_VAL, 0, 0);
        push_req(OP_DEL_VAL, 0, 12345);          // absent
        push_req(OP_COUNT, 0, 0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin snd_idle_pct = 25; rcv_idle_pct = 70; end
                1: begin snd_idle_pct = 70; rcv_idle_pct = 25; end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            grow = 75;
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (i % 32 == 31)
                    grow = (grow == 75) ? 30 : 75;
                pending_reqs.push_back(make_req(grow));
            end
            // sender pauses until every result is back
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (error_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
